FILE: rtl/point_in_polygon_test_macros.svh
// Assertion macros shared by the point-in-polygon test RTL.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define PIP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// A condition that must never be seen at a clock edge out of reset.
`define PIP_NEVER(lbl, cond, msg) \
    `PIP_ASSERT(lbl, !(cond), msg)

`endif

FILE: rtl/pip_pkg.sv
// Shared constants and types for the point-in-polygon test block.
// No dependencies; used by pip_front, pip_back and the top level.
`timescale 1ns / 1ps

package pip_pkg;

    // Vertex store size and derived widths.
    localparam int MAX_VERTICES = 64;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    // Fixed field widths of the item and configuration ports.
    localparam int COORD_W = 16;
    localparam int IDX_W   = 6;
    localparam int CFG_W   = 7;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 2;

    // Request codes carried by req_type.
    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_TEST = 1'b1
    } t_req;

    // A classified item as it travels from the front to the back.
    // For a load x/y hold the vertex, for a test they hold the point.
    typedef struct packed {
        logic                       is_test;
        logic [ADDR_W-1:0]          slot;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
    } t_cmd;

endpackage

FILE: rtl/point_in_polygon_test.sv
// Point-in-polygon test, top level: joins the front queue and the back.
// Depends on pip_pkg, pip_front and pip_back.
//
// Use: items enter through push/full. A load item (req_type 0) writes one
// vertex into slot vertex_index and gives no result. A test item (req_type 1)
// carries a point and gives one item on o_inside_res, 1 when the point lies
// inside the polygon formed by the first vertex_count vertices.
// Results leave through empty/pop; the oldest is shown while empty is low.
// vertex_count is written on its own valid/ready channel, ready always high;
// the user writes it only while the block is idle, unchecked by the block.
// Values above 64 are taken as 64. A load is written to the store while the
// back is idle; a test steps through LDJ, EA and EB per edge (one store read
// port), FIN and DONE, where its result shows, or straight to DONE with no
// vertices. Throughput: a load a cycle while the back is idle; no item is
// taken until a test leaves DONE. Stall: a held result waits in the output
// register; loads keep flowing and a following test runs to its end, then
// waits for pop. full rises when the two-entry front queue is taken.
// Reset clears the queue, the result register and vertex_count; the vertex
// store keeps whatever it held and must be loaded before use.
`timescale 1ns / 1ps

module point_in_polygon_test (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               i_req_type,
    input  logic [pip_pkg::IDX_W-1:0]          i_vertex_index,
    input  logic signed [pip_pkg::COORD_W-1:0] i_vertex_x,
    input  logic signed [pip_pkg::COORD_W-1:0] i_vertex_y,
    input  logic signed [pip_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [pip_pkg::COORD_W-1:0] i_point_y,
    output logic                               empty,
    input  logic                               pop,
    output logic                               o_inside_res,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pip_pkg::CFG_W-1:0]          i_cfg_vertex_count
);

    logic          cmd_valid;
    logic          cmd_pop;
    pip_pkg::t_cmd cmd;

    // Front: accepts and classifies items into a short queue.
    pip_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_req_type     (i_req_type),
        .i_vertex_index (i_vertex_index),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    // Back: vertex store, edge walk and result register.
    pip_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_vertex_count (i_cfg_vertex_count),
        .i_cmd_valid        (cmd_valid),
        .i_cmd              (cmd),
        .o_cmd_pop          (cmd_pop),
        .o_empty            (empty),
        .i_pop              (pop),
        .o_inside_res       (o_inside_res)
    );

endmodule

FILE: rtl/pip_front.sv
// Front of the point-in-polygon test: accepts items, classifies them and
// queues them for the back. Depends on pip_pkg.
`timescale 1ns / 1ps

module pip_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               i_req_type,
    input  logic [pip_pkg::IDX_W-1:0]          i_vertex_index,
    input  logic signed [pip_pkg::COORD_W-1:0] i_vertex_x,
    input  logic signed [pip_pkg::COORD_W-1:0] i_vertex_y,
    input  logic signed [pip_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [pip_pkg::COORD_W-1:0] i_point_y,
    output logic                               o_cmd_valid,
    output pip_pkg::t_cmd                      o_cmd,
    input  logic                               i_cmd_pop
);

    localparam int QPTR_W = $clog2(pip_pkg::QDEPTH);
    localparam int QCNT_W = $clog2(pip_pkg::QDEPTH + 1);

    pip_pkg::t_cmd     r_queue [pip_pkg::QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    pip_pkg::t_cmd     n_cmd;
    logic              keep;
    logic              accept;
    logic              wr;
    logic              rd;

    // Classify the incoming item and pick the coordinates it carries.
    always_comb begin
        n_cmd.is_test = (i_req_type == pip_pkg::REQ_TEST);
        n_cmd.slot    = pip_pkg::ADDR_W'(i_vertex_index);
        n_cmd.x       = n_cmd.is_test ? i_point_x : i_vertex_x;
        n_cmd.y       = n_cmd.is_test ? i_point_y : i_vertex_y;
    end

    // A load aimed beyond the store is accepted but dropped here.
    assign keep   = n_cmd.is_test || (int'(i_vertex_index) < pip_pkg::MAX_VERTICES);
    assign accept = push && !full;
    assign wr     = accept && keep;
    assign rd     = o_cmd_valid && i_cmd_pop;

    assign full        = (r_count == QCNT_W'(pip_pkg::QDEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];

    // Queue pointers and fill count; the depth is a power of two so the
    // pointers simply wrap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= QPTR_W'(r_wr_ptr + 1'b1);
            end
            if (rd) begin
                r_rd_ptr <= QPTR_W'(r_rd_ptr + 1'b1);
            end
            if (wr && !rd) begin
                r_count <= QCNT_W'(r_count + 1'b1);
            end else if (rd && !wr) begin
                r_count <= QCNT_W'(r_count - 1'b1);
            end
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_queue[r_wr_ptr] <= n_cmd;
        end
    end

endmodule

FILE: rtl/pip_back.sv
// Back of the point-in-polygon test: vertex store, edge walk and result
// register. Depends on pip_pkg and point_in_polygon_test_macros.svh.
`timescale 1ns / 1ps
`include "point_in_polygon_test_macros.svh"

module pip_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pip_pkg::CFG_W-1:0]          i_cfg_vertex_count,
    input  logic                               i_cmd_valid,
    input  pip_pkg::t_cmd                      i_cmd,
    output logic                               o_cmd_pop,
    output logic                               o_empty,
    input  logic                               i_pop,
    output logic                               o_inside_res
);

    localparam int DIFF_W = pip_pkg::COORD_W + 1;
    localparam int LHS_W  = DIFF_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int MUL_W  = LHS_W + DIFF_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LDJ,
        S_EA,
        S_EB,
        S_FIN,
        S_DONE
    } t_state;

    t_state                             r_state;
    logic [pip_pkg::CNT_W-1:0]          r_vcount;
    logic [pip_pkg::ADDR_W-1:0]         r_i;
    logic                               r_c_v;
    logic                               r_inside;
    logic                               r_out_v;
    logic                               r_out;

    logic [2*pip_pkg::COORD_W-1:0]      r_mem [pip_pkg::MAX_VERTICES];
    logic [2*pip_pkg::COORD_W-1:0]      r_rd;
    logic [pip_pkg::ADDR_W-1:0]         rd_addr;
    logic                               mem_we;

    logic signed [pip_pkg::COORD_W-1:0] r_px;
    logic signed [pip_pkg::COORD_W-1:0] r_py;
    logic signed [pip_pkg::COORD_W-1:0] r_xj;
    logic signed [pip_pkg::COORD_W-1:0] r_yj;

    logic signed [PROD_W-1:0]           r_pa;
    logic signed [DIFF_W-1:0]           r_ta;
    logic signed [DIFF_W-1:0]           r_da;
    logic                               r_sa;
    logic signed [MUL_W-1:0]            r_mb;
    logic signed [PROD_W-1:0]           r_pb;
    logic                               r_pgeb;
    logic                               r_sb;

    logic signed [pip_pkg::COORD_W-1:0] xi;
    logic signed [pip_pkg::COORD_W-1:0] yi;
    logic                               a_strad;
    logic                               a_neg;
    logic signed [DIFF_W-1:0]           a_dx;
    logic signed [DIFF_W-1:0]           a_dyp;
    logic signed [DIFF_W-1:0]           a_den;
    logic signed [DIFF_W-1:0]           a_t;
    logic signed [PROD_W-1:0]           a_prod;
    logic                               b_pge;
    logic signed [LHS_W-1:0]            b_lhs;
    logic signed [MUL_W-1:0]            b_m;
    logic signed [MUL_W-1:0]            c_p;
    logic                               c_cross;
    logic                               test_start;

    function automatic logic signed [DIFF_W-1:0] sx(
        input logic signed [pip_pkg::COORD_W-1:0] v
    );
        return {v[pip_pkg::COORD_W-1], v};
    endfunction

    assign o_cfg_ready  = 1'b1;
    assign o_cmd_pop    = (r_state == S_IDLE);
    assign o_empty      = !r_out_v;
    assign o_inside_res = r_out;
    assign mem_we       = (r_state == S_IDLE) && i_cmd_valid && !i_cmd.is_test;
    assign test_start   = (r_state == S_IDLE) && i_cmd_valid && i_cmd.is_test;

    assign xi = r_rd[2*pip_pkg::COORD_W-1:pip_pkg::COORD_W];
    assign yi = r_rd[pip_pkg::COORD_W-1:0];

    // Read address: the last vertex first, then vertex 0, then one ahead
    // of the edge being worked on.
    always_comb begin
        unique case (r_state)
            S_IDLE:  rd_addr = pip_pkg::ADDR_W'(r_vcount - 1'b1);
            S_LDJ:   rd_addr = '0;
            default: rd_addr = pip_pkg::ADDR_W'(r_i + 1'b1);
        endcase
    end

    // Vertex store with a registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_cmd.slot] <= {i_cmd.x, i_cmd.y};
        end
        r_rd <= r_mem[rd_addr];
    end

    // Stage A: straddle test and the signed product. The divisor is made
    // positive by swapping the subtraction order of the x and y differences.
    always_comb begin
        a_strad = (yi > r_py) != (r_yj > r_py);
        a_neg   = (r_yj < yi);
        a_dx    = a_neg ? (sx(xi) - sx(r_xj)) : (sx(r_xj) - sx(xi));
        a_den   = a_neg ? (sx(yi) - sx(r_yj)) : (sx(r_yj) - sx(yi));
        a_dyp   = sx(r_py) - sx(yi);
        a_t     = sx(r_px) - sx(xi);
        a_prod  = a_dx * a_dyp;
    end

    // Stage B: with D > 0 and t = px - xi, t < trunc(P / D) holds exactly
    // when (t + 1) * D <= P for P >= 0, and when t * D < P for P < 0.
    always_comb begin
        b_pge = !r_pa[PROD_W-1];
        b_lhs = {r_ta[DIFF_W-1], r_ta} + {{DIFF_W{1'b0}}, b_pge};
        b_m   = b_lhs * r_da;
    end

    // Stage C: the compare that decides a crossing.
    always_comb begin
        c_p     = {r_pb[PROD_W-1], r_pb};
        c_cross = r_pgeb ? (r_mb <= c_p) : (r_mb < c_p);
    end

    // Sequencer, crossing parity, configuration and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vcount <= '0;
            r_i      <= '0;
            r_c_v    <= 1'b0;
            r_inside <= 1'b0;
            r_out_v  <= 1'b0;
            r_out    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_vcount <= (int'(i_cfg_vertex_count) > pip_pkg::MAX_VERTICES)
                          ? pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES)
                          : pip_pkg::CNT_W'(i_cfg_vertex_count);
            end
            r_c_v <= (r_state == S_EB);
            if (r_c_v && r_sb && c_cross) begin
                r_inside <= !r_inside;
            end
            // A result taken while another is ready is replaced below.
            if (i_pop && r_out_v && (r_state != S_DONE)) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (test_start) begin
                        r_inside <= 1'b0;
                        r_state  <= (r_vcount == '0) ? S_DONE : S_LDJ;
                    end
                end
                S_LDJ: begin
                    r_i     <= '0;
                    r_state <= S_EA;
                end
                S_EA: begin
                    r_state <= S_EB;
                end
                S_EB: begin
                    r_i <= pip_pkg::ADDR_W'(r_i + 1'b1);
                    if (pip_pkg::CNT_W'(r_i) == pip_pkg::CNT_W'(r_vcount - 1'b1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_EA;
                    end
                end
                S_FIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_v || i_pop) begin
                        r_out_v <= 1'b1;
                        r_out   <= r_inside;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers of the walk need no reset.
    always_ff @(posedge i_clk) begin
        if (test_start) begin
            r_px <= i_cmd.x;
            r_py <= i_cmd.y;
        end
        if ((r_state == S_LDJ) || (r_state == S_EA)) begin
            r_xj <= xi;
            r_yj <= yi;
        end
        if (r_state == S_EA) begin
            r_pa <= a_prod;
            r_ta <= a_t;
            r_da <= a_den;
            r_sa <= a_strad;
        end
        if (r_state == S_EB) begin
            r_mb   <= b_m;
            r_pb   <= r_pa;
            r_pgeb <= b_pge;
            r_sb   <= r_sa;
        end
    end

    // Checks on the walk and the result register.
    `PIP_ASSERT(a_stage_c_after_eb, r_c_v |-> $past(r_state == S_EB), "compare without product")
    `PIP_ASSERT(a_result_from_done, $rose(r_out_v) |-> $past(r_state == S_DONE), "stray result")
    `PIP_ASSERT(a_walk_in_range, (r_state == S_EB) |-> (pip_pkg::CNT_W'(r_i) < r_vcount), "edge index past count")
    `PIP_NEVER(a_vcount_range, r_vcount > pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES), "vertex count too large")

endmodule
